FILE: sv/acit_pkg.sv
// shared operation codes, register offsets and constants for the i/o timer block
package acit_pkg;

	// item operation codes
	typedef enum logic [2:0] {
		OP_CPU_READ   = 3'd0,
		OP_CPU_WRITE  = 3'd1,
		OP_TICK       = 3'd2,
		OP_HOST_WRITE = 3'd3,
		OP_HOST_READ  = 3'd4
	} op_t;

	// register offsets within the window
	localparam logic [3:0] OFF_TEST     = 4'h0;
	localparam logic [3:0] OFF_CONTROL  = 4'h1;
	localparam logic [3:0] OFF_DSP_ADDR = 4'h2;
	localparam logic [3:0] OFF_DSP_DATA = 4'h3;
	localparam logic [3:0] OFF_PORT0    = 4'h4;
	localparam logic [3:0] OFF_PORT1    = 4'h5;
	localparam logic [3:0] OFF_PORT2    = 4'h6;
	localparam logic [3:0] OFF_PORT3    = 4'h7;
	localparam logic [3:0] OFF_SPARE0   = 4'h8;
	localparam logic [3:0] OFF_SPARE1   = 4'h9;
	localparam logic [3:0] OFF_TARGET0  = 4'hA;
	localparam logic [3:0] OFF_TARGET1  = 4'hB;
	localparam logic [3:0] OFF_TARGET2  = 4'hC;
	localparam logic [3:0] OFF_COUNT0   = 4'hD;
	localparam logic [3:0] OFF_COUNT1   = 4'hE;
	localparam logic [3:0] OFF_COUNT2   = 4'hF;

	// control register layout
	localparam logic [7:0] CONTROL_RESET = 8'h80;
	localparam int unsigned CTRL_CLEAR_LO = 4;
	localparam int unsigned CTRL_CLEAR_HI = 5;
	localparam int unsigned CTRL_ROM      = 7;

	// timers
	localparam int unsigned NUM_TIMERS  = 3;
	localparam logic [8:0]  TARGET_ZERO = 9'd256;

endpackage

FILE: sv/audio_cpu_io_timer_block.sv
// top level: i/o register window with three interval timers
//
// Input channel (in_valid/in_ready) carries one word per item: operation,
// reg_offset and write_data. Operations are cpu read, cpu write, clock tick,
// host port write and host port read. Output channel (out_valid/out_ready)
// returns exactly one word per item: read_data and rom_enabled (control
// bit 7 after the item has taken effect).
// The word accepted at one edge is loaded into the output register at that
// edge and is shown from the next cycle on. Throughput is one item per
// cycle while the output is not stalled; all state updates happen at the
// accepting edge through a single pass of short logic (prescaler compare,
// 9-bit stage compare per timer, register select).
// in_ready is high whenever the output register is empty or being taken in
// the same cycle, so a stalled receiver holds back at most one word and the
// block then stops taking items until that word leaves.
// Reset (arst_n low) sets control to 0x80 (boot rom on), clears every other
// register, the prescalers and the timers, and empties the output register.
module audio_cpu_io_timer_block
	import acit_pkg::*;
#(
	parameter int unsigned SLOW_DIVIDE = 128,
	parameter int unsigned FAST_DIVIDE = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] operation,
	input  logic [3:0] reg_offset,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       rom_enabled
);

	localparam int unsigned SLOW_W = $clog2(SLOW_DIVIDE);
	localparam int unsigned FAST_W = $clog2(FAST_DIVIDE);
	localparam logic [SLOW_W-1:0] SLOW_LAST = SLOW_W'(SLOW_DIVIDE - 1);
	localparam logic [FAST_W-1:0] FAST_LAST = FAST_W'(FAST_DIVIDE - 1);

	// architectural state
	logic [7:0]        control_q, control_d;
	logic [7:0]        dsp_addr_q, dsp_addr_d;
	logic [7:0]        in_ports_q [4];
	logic [7:0]        in_ports_d [4];
	logic [7:0]        out_ports_q [4];
	logic [7:0]        out_ports_d [4];
	logic [7:0]        spare_q [2];
	logic [7:0]        spare_d [2];
	logic [7:0]        target_q [NUM_TIMERS];
	logic [7:0]        target_d [NUM_TIMERS];
	logic [7:0]        stage_q [NUM_TIMERS];
	logic [7:0]        stage_d [NUM_TIMERS];
	logic [3:0]        count_q [NUM_TIMERS];
	logic [3:0]        count_d [NUM_TIMERS];
	logic [SLOW_W-1:0] slow_q, slow_d;
	logic [FAST_W-1:0] fast_q, fast_d;

	// result register
	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic       rom_q;

	logic       accept;
	logic [7:0] rd_d;
	logic       slow_wrap;
	logic       fast_wrap;
	logic [NUM_TIMERS-1:0] step_en;
	logic [1:0] target_idx;
	logic [1:0] count_idx;

	assign in_ready    = !out_valid_q || out_ready;
	assign accept      = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign rom_enabled = rom_q;

	// prescaler wrap detection
	assign slow_wrap = (slow_q == SLOW_LAST);
	assign fast_wrap = (fast_q == FAST_LAST);
	assign step_en   = {control_q[2] && fast_wrap,
	                    control_q[1] && slow_wrap,
	                    control_q[0] && slow_wrap};

	assign target_idx = 2'(reg_offset - OFF_TARGET0);
	assign count_idx  = 2'(reg_offset - OFF_COUNT0);

	// next state and read word for the offered item
	always_comb begin
		logic [8:0] stage_inc;
		logic [8:0] limit;
		control_d   = control_q;
		dsp_addr_d  = dsp_addr_q;
		in_ports_d  = in_ports_q;
		out_ports_d = out_ports_q;
		spare_d     = spare_q;
		target_d    = target_q;
		stage_d     = stage_q;
		count_d     = count_q;
		slow_d      = slow_q;
		fast_d      = fast_q;
		rd_d        = 8'h00;
		stage_inc   = 9'd0;
		limit       = 9'd0;
		case (op_t'(operation))
			OP_CPU_READ: begin
				case (reg_offset)
					OFF_DSP_ADDR: rd_d = dsp_addr_q;
					OFF_PORT0, OFF_PORT1, OFF_PORT2, OFF_PORT3: begin
						rd_d = in_ports_q[reg_offset[1:0]];
					end
					OFF_SPARE0, OFF_SPARE1: rd_d = spare_q[reg_offset[0]];
					OFF_COUNT0, OFF_COUNT1, OFF_COUNT2: begin
						rd_d = {4'h0, count_q[count_idx]};
						count_d[count_idx] = 4'h0;
					end
					default: rd_d = 8'h00;
				endcase
			end
			OP_CPU_WRITE: begin
				case (reg_offset)
					OFF_CONTROL: begin
						control_d = write_data;
						if (write_data[CTRL_CLEAR_LO]) begin
							in_ports_d[0] = 8'h00;
							in_ports_d[1] = 8'h00;
						end
						if (write_data[CTRL_CLEAR_HI]) begin
							in_ports_d[2] = 8'h00;
							in_ports_d[3] = 8'h00;
						end
					end
					OFF_DSP_ADDR: dsp_addr_d = write_data;
					OFF_PORT0, OFF_PORT1, OFF_PORT2, OFF_PORT3: begin
						out_ports_d[reg_offset[1:0]] = write_data;
					end
					OFF_SPARE0, OFF_SPARE1: spare_d[reg_offset[0]] = write_data;
					OFF_TARGET0, OFF_TARGET1, OFF_TARGET2: begin
						target_d[target_idx] = write_data;
					end
					default: ;
				endcase
			end
			OP_TICK: begin
				slow_d = slow_wrap ? '0 : slow_q + 1'b1;
				fast_d = fast_wrap ? '0 : fast_q + 1'b1;
				for (int t = 0; t < NUM_TIMERS; t++) begin
					stage_inc = {1'b0, stage_q[t]} + 9'd1;
					limit     = (target_q[t] == 8'h00) ? TARGET_ZERO : {1'b0, target_q[t]};
					if (step_en[t]) begin
						if (stage_inc >= limit) begin
							stage_d[t] = 8'h00;
							count_d[t] = count_q[t] + 4'd1;
						end else begin
							stage_d[t] = stage_inc[7:0];
						end
					end
				end
			end
			OP_HOST_WRITE: in_ports_d[reg_offset[1:0]] = write_data;
			OP_HOST_READ:  rd_d = out_ports_q[reg_offset[1:0]];
			default: ;
		endcase
	end

	// state registers, updated on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q  <= CONTROL_RESET;
			dsp_addr_q <= 8'h00;
			slow_q     <= '0;
			fast_q     <= '0;
			for (int i = 0; i < 4; i++) begin
				in_ports_q[i]  <= 8'h00;
				out_ports_q[i] <= 8'h00;
			end
			for (int i = 0; i < 2; i++) begin
				spare_q[i] <= 8'h00;
			end
			for (int t = 0; t < NUM_TIMERS; t++) begin
				target_q[t] <= 8'h00;
				stage_q[t]  <= 8'h00;
				count_q[t]  <= 4'h0;
			end
		end else if (accept) begin
			control_q   <= control_d;
			dsp_addr_q  <= dsp_addr_d;
			slow_q      <= slow_d;
			fast_q      <= fast_d;
			in_ports_q  <= in_ports_d;
			out_ports_q <= out_ports_d;
			spare_q     <= spare_d;
			target_q    <= target_d;
			stage_q     <= stage_d;
			count_q     <= count_d;
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q <= rd_d;
			rom_q       <= control_d[CTRL_ROM];
		end
	end

endmodule

FILE: sv/acit_checker.sv
// port-level checker for the i/o timer block, with its bind
module acit_checker
	import acit_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [2:0] operation,
	input logic [3:0] reg_offset,
	input logic [7:0] write_data,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] read_data,
	input logic       rom_enabled
);

	logic in_take;
	assign in_take = in_valid && in_ready;

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(rom_enabled))
		else $error("output word changed while stalled");

	// an empty output register never blocks the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// every accepted word shows a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> out_valid)
		else $error("accepted word produced no result");

	// writes and ticks read back zero
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && (operation == OP_CPU_WRITE || operation == OP_TICK ||
		            operation == OP_HOST_WRITE) |=> read_data == 8'h00)
		else $error("non-read word returned data");

	// control write sets the boot rom flag at once
	a_rom_update: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && operation == OP_CPU_WRITE && reg_offset == OFF_CONTROL
		|=> rom_enabled == $past(write_data[CTRL_ROM]))
		else $error("boot rom flag not taken from control write");

endmodule

bind audio_cpu_io_timer_block acit_checker u_acit_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.operation   (operation),
	.reg_offset  (reg_offset),
	.write_data  (write_data),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.read_data   (read_data),
	.rom_enabled (rom_enabled)
);
